>>> hw/rtl/pdc_pkg.sv
// pdc_pkg: shared widths, reset values, register codes and structs for the
// pid drive controller. No dependencies; imported by every pdc module.
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

  localparam int unsigned POS_WIDTH_DEF = 24;
  localparam int unsigned MOTORS_DEF    = 3;
  localparam int unsigned POS_FIELDS    = 3;   // position ports per side

  localparam int unsigned ERR_W  = 26;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned GAIN_W = 32;
  localparam int unsigned ILIM_W = 31;
  localparam int unsigned PLIM_W = 11;
  localparam int unsigned PWR_W  = 12;
  localparam int unsigned FRAC_W = 24;         // gain fraction bits

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 32'd1174405;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 32'd2181;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 32'd209715;
  localparam logic [ILIM_W-1:0] ILIM_RST   = 31'd80000;
  localparam logic [PLIM_W-1:0] PLIM_RST   = 11'd536;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_PWR_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [ILIM_W-1:0] integral_limit;
    logic [PLIM_W-1:0] power_limit;
  } pdc_cfg_t;

  typedef struct packed {
    logic active;   // setpoint non-zero
    logic clear;
    logic turn;
  } pdc_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/pdc_cfg.sv
// pdc_cfg: apb-style register file holding gains and limits.
// Depends on pdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdc_cfg (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [pdc_pkg::APB_AW-1:0]   paddr,
  input  wire [pdc_pkg::APB_DW-1:0]   pwdata,
  output logic [pdc_pkg::APB_DW-1:0]  prdata,
  output pdc_pkg::pdc_cfg_t           cfg_o
);
  import pdc_pkg::*;

  logic [GAIN_W-1:0] gain_p_r;
  logic [GAIN_W-1:0] gain_i_r;
  logic [GAIN_W-1:0] gain_d_r;
  logic [ILIM_W-1:0] ilim_r;
  logic [PLIM_W-1:0] plim_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
      ilim_r   <= ILIM_RST;
      plim_r   <= PLIM_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:    gain_p_r <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_r <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_r <= pwdata[GAIN_W-1:0];
        REG_INT_LIMIT: ilim_r   <= pwdata[ILIM_W-1:0];
        REG_PWR_LIMIT: plim_r   <= pwdata[PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GAIN_P:    prdata = APB_DW'(gain_p_r);
      REG_GAIN_I:    prdata = APB_DW'(gain_i_r);
      REG_GAIN_D:    prdata = APB_DW'(gain_d_r);
      REG_INT_LIMIT: prdata = APB_DW'(ilim_r);
      REG_PWR_LIMIT: prdata = APB_DW'(plim_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = '{gain_p: gain_p_r, gain_i: gain_i_r, gain_d: gain_d_r,
                   integral_limit: ilim_r, power_limit: plim_r};

endmodule

`default_nettype wire

>>> hw/rtl/pdc_meas.sv
// pdc_meas: input register, position averaging and error forming (four stages).
// Depends on pdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdc_meas #(
  parameter int unsigned POS_WIDTH       = pdc_pkg::POS_WIDTH_DEF,
  parameter int unsigned MOTORS_PER_SIDE = pdc_pkg::MOTORS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        adv,
  input  wire                        in_valid,
  input  wire [POS_WIDTH-1:0]        setpoint,
  input  wire [POS_WIDTH-1:0]        left_pos_a,
  input  wire [POS_WIDTH-1:0]        left_pos_b,
  input  wire [POS_WIDTH-1:0]        left_pos_c,
  input  wire [POS_WIDTH-1:0]        right_pos_a,
  input  wire [POS_WIDTH-1:0]        right_pos_b,
  input  wire [POS_WIDTH-1:0]        right_pos_c,
  input  wire                        clear_request,
  input  wire                        turning_mode,
  output logic                       vld_o,
  output pdc_pkg::pdc_flags_t        flags_o,
  output logic [pdc_pkg::ERR_W-1:0]  err_o
);
  import pdc_pkg::*;

  localparam int unsigned PW     = POS_WIDTH;
  localparam int unsigned N_USED = (MOTORS_PER_SIDE > 3) ? 3 :
                                   ((MOTORS_PER_SIDE < 1) ? 1 : MOTORS_PER_SIDE);
  localparam int unsigned SUM_W  = PW + 3;
  localparam int unsigned MAG_W  = PW + 1;
  localparam int unsigned SH_T   = (N_USED == 2) ? 1 : 0;
  localparam int unsigned SH_S   = (N_USED == 2) ? 2 : 1;
  localparam bit          DIV3   = (N_USED == 3);
  localparam int unsigned SHIFT_S = MAG_W + 2;
  localparam int unsigned RW     = MAG_W + 1;
  localparam int unsigned LO_W   = (MAG_W + 1) / 2;
  localparam int unsigned HI_W   = MAG_W - LO_W;
  localparam int unsigned FULL_W = MAG_W + RW + 1;
  localparam int unsigned DW     = PW + 2;
  localparam int unsigned EXT_W  = ((DW > ERR_W) ? DW : ERR_W) + 1;
  // ceil(2^SHIFT_S / 3): exact floor division for any MAG_W-bit value
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SHIFT_S) + 64'd2) / 64'd3);
  localparam logic signed [EXT_W-1:0] ERR_HI =
    {{(EXT_W-ERR_W+1){1'b0}}, {(ERR_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] ERR_LO =
    {{(EXT_W-ERR_W+1){1'b1}}, {(ERR_W-1){1'b0}}};

  // stage 0: input register
  logic             v0_r;
  logic [PW-1:0]    sp0_r;
  logic [PW-1:0]    lp0_r [POS_FIELDS];
  logic [PW-1:0]    rp0_r [POS_FIELDS];
  logic             clr0_r;
  logic             turn0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp0_r    <= setpoint;
      lp0_r[0] <= left_pos_a;
      lp0_r[1] <= left_pos_b;
      lp0_r[2] <= left_pos_c;
      rp0_r[0] <= right_pos_a;
      rp0_r[1] <= right_pos_b;
      rp0_r[2] <= right_pos_c;
      clr0_r   <= clear_request;
      turn0_r  <= turning_mode;
    end
  end

  // stage 1: side sums and magnitude to divide
  logic [SUM_W-1:0] lsum;
  logic [SUM_W-1:0] rsum;
  logic [SUM_W-1:0] tot;
  logic [SUM_W-1:0] r_abs;
  logic [SUM_W-1:0] t_abs;
  logic [SUM_W-1:0] r_sh;
  logic [SUM_W-1:0] t_sh;
  logic [MAG_W-1:0] mag_nxt;
  logic             neg_nxt;

  always_comb begin
    lsum = '0;
    rsum = '0;
    for (int k = 0; k < N_USED; k++) begin
      lsum = lsum + {{(SUM_W-PW){lp0_r[k][PW-1]}}, lp0_r[k]};
      rsum = rsum + {{(SUM_W-PW){rp0_r[k][PW-1]}}, rp0_r[k]};
    end
    tot   = lsum + rsum;
    r_abs = rsum[SUM_W-1] ? (~rsum + 1'b1) : rsum;
    t_abs = tot[SUM_W-1] ? (~tot + 1'b1) : tot;
    r_sh  = r_abs >> SH_T;
    t_sh  = t_abs >> SH_S;
    if (turn0_r) begin
      mag_nxt = r_sh[MAG_W-1:0];
      neg_nxt = rsum[SUM_W-1];
    end else begin
      mag_nxt = t_sh[MAG_W-1:0];
      neg_nxt = tot[SUM_W-1];
    end
  end

  logic             v1_r;
  logic [MAG_W-1:0] mag1_r;
  logic             neg1_r;
  logic [PW-1:0]    sp1_r;
  pdc_flags_t       flags1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r   <= mag_nxt;
      neg1_r   <= neg_nxt;
      sp1_r    <= sp0_r;
      flags1_r <= '{active: (sp0_r != '0), clear: clr0_r, turn: turn0_r};
    end
  end

  // stage 2: reciprocal multiply, split in two halves
  logic [LO_W+RW-1:0] plo_nxt;
  logic [HI_W+RW-1:0] phi_nxt;

  assign plo_nxt = mag1_r[LO_W-1:0] * RECIP;
  assign phi_nxt = mag1_r[MAG_W-1:LO_W] * RECIP;

  logic               v2_r;
  logic [LO_W+RW-1:0] plo2_r;
  logic [HI_W+RW-1:0] phi2_r;
  logic [MAG_W-1:0]   mag2_r;
  logic               neg2_r;
  logic [PW-1:0]      sp2_r;
  pdc_flags_t         flags2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plo2_r   <= plo_nxt;
      phi2_r   <= phi_nxt;
      mag2_r   <= mag1_r;
      neg2_r   <= neg1_r;
      sp2_r    <= sp1_r;
      flags2_r <= flags1_r;
    end
  end

  // stage 3: quotient, sign, error and its saturation
  logic [FULL_W-1:0]       full;
  logic [FULL_W-1:0]       q_sh;
  logic [MAG_W-1:0]        quot;
  logic [DW-1:0]           quot_ext;
  logic [DW-1:0]           meas;
  logic [DW-1:0]           diff;
  logic signed [EXT_W-1:0] dx;
  logic signed [EXT_W-1:0] dsat;
  logic [ERR_W-1:0]        err_nxt;

  always_comb begin
    full     = FULL_W'({phi2_r, {LO_W{1'b0}}}) + FULL_W'(plo2_r);
    q_sh     = full >> SHIFT_S;
    quot     = DIV3 ? q_sh[MAG_W-1:0] : mag2_r;
    quot_ext = DW'(quot);
    meas     = neg2_r ? (~quot_ext + 1'b1) : quot_ext;
    diff     = {{(DW-PW){sp2_r[PW-1]}}, sp2_r} - meas;
    dx       = {{(EXT_W-DW){diff[DW-1]}}, diff};
    if (dx > ERR_HI) begin
      dsat = ERR_HI;
    end else if (dx < ERR_LO) begin
      dsat = ERR_LO;
    end else begin
      dsat = dx;
    end
    err_nxt = dsat[ERR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_o   <= err_nxt;
      flags_o <= flags2_r;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pdc_law.sv
// pdc_law: integral and derivative state, gain products, power saturation
// and the result register. Depends on pdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdc_law (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        adv,
  input  wire                        vld_i,
  input  wire pdc_pkg::pdc_flags_t   flags_i,
  input  wire [pdc_pkg::ERR_W-1:0]   err_i,
  input  wire pdc_pkg::pdc_cfg_t     cfg_i,
  output logic                       out_valid,
  output logic [pdc_pkg::PWR_W-1:0]  drive_power,
  output logic                       pivot_drive,
  output logic                       clear_encoders
);
  import pdc_pkg::*;

  localparam int unsigned TP_W    = ERR_W + GAIN_W + 1;
  localparam int unsigned TI_W    = ACC_W + GAIN_W + 1;
  localparam int unsigned TD_W    = ERR_W + GAIN_W + 2;
  localparam int unsigned TERM_SH = 60;
  localparam int unsigned SUMP_W  = TERM_SH + 3;
  localparam logic signed [TI_W-1:0] TI_HI =
    {{(TI_W-TERM_SH-1){1'b0}}, 1'b1, {TERM_SH{1'b0}}};
  localparam logic signed [TI_W-1:0] TI_LO = -TI_HI;
  localparam logic signed [SUMP_W-1:0] RND =
    {{(SUMP_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

  // stage 4: state update, closed through the integral_r and last_err_r registers
  logic signed [ACC_W-1:0] integral_r;
  logic signed [ERR_W-1:0] last_err_r;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W:0]   lim_pos;
  logic signed [ACC_W:0]   lim_neg;
  logic signed [ACC_W-1:0] acc_clamped;
  logic signed [ACC_W-1:0] integral_nxt;
  logic signed [ERR_W:0]   der_nxt;

  always_comb begin
    acc_base = flags_i.clear ? '0 : integral_r;
    acc_sum  = {acc_base[ACC_W-1], acc_base} +
               {{(ACC_W+1-ERR_W){err_i[ERR_W-1]}}, err_i};
    lim_pos  = {2'b00, cfg_i.integral_limit};
    lim_neg  = -lim_pos;
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos[ACC_W-1:0];
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg[ACC_W-1:0];
    end else begin
      acc_clamped = acc_sum[ACC_W-1:0];
    end
    integral_nxt = flags_i.active ? acc_clamped : acc_base;
    der_nxt      = {err_i[ERR_W-1], err_i} - {last_err_r[ERR_W-1], last_err_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      last_err_r <= '0;
    end else if (adv && vld_i) begin
      integral_r <= integral_nxt;
      if (flags_i.active) begin
        last_err_r <= err_i;
      end
    end
  end

  logic                    v4_r;
  logic signed [ERR_W-1:0] err4_r;
  logic signed [ACC_W-1:0] acc4_r;
  logic signed [ERR_W:0]   der4_r;
  pdc_flags_t              flags4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err4_r   <= err_i;
      acc4_r   <= integral_nxt;
      der4_r   <= der_nxt;
      flags4_r <= flags_i;
    end
  end

  // stage 5: the three gain products
  logic signed [GAIN_W:0] gp_s;
  logic signed [GAIN_W:0] gi_s;
  logic signed [GAIN_W:0] gd_s;
  logic signed [TP_W-1:0] tp_nxt;
  logic signed [TI_W-1:0] ti_nxt;
  logic signed [TD_W-1:0] td_nxt;

  always_comb begin
    gp_s   = {1'b0, cfg_i.gain_p};
    gi_s   = {1'b0, cfg_i.gain_i};
    gd_s   = {1'b0, cfg_i.gain_d};
    tp_nxt = err4_r * gp_s;
    ti_nxt = acc4_r * gi_s;
    td_nxt = der4_r * gd_s;
  end

  logic                   v5_r;
  logic signed [TP_W-1:0] tp5_r;
  logic signed [TI_W-1:0] ti5_r;
  logic signed [TD_W-1:0] td5_r;
  pdc_flags_t             flags5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tp5_r    <= tp_nxt;
      ti5_r    <= ti_nxt;
      td5_r    <= td_nxt;
      flags5_r <= flags4_r;
    end
  end

  // stage 6: sum, saturate to the power limit, round to a signed integer (q12.0)
  logic signed [TI_W-1:0]   ti_cl;
  logic signed [SUMP_W-1:0] ti_c;
  logic signed [SUMP_W-1:0] sum;
  logic signed [SUMP_W-1:0] pl;
  logic signed [SUMP_W-1:0] rnd;
  logic [PWR_W-1:0]         plim_ext;
  logic [PWR_W-1:0]         pwr;
  logic [PWR_W-1:0]         power_nxt;

  always_comb begin
    if (ti5_r > TI_HI) begin
      ti_cl = TI_HI;
    end else if (ti5_r < TI_LO) begin
      ti_cl = TI_LO;
    end else begin
      ti_cl = ti5_r;
    end
    ti_c     = ti_cl[SUMP_W-1:0];
    sum      = SUMP_W'(tp5_r) + ti_c + SUMP_W'(td5_r);
    pl       = {{(SUMP_W-PLIM_W-FRAC_W){1'b0}}, cfg_i.power_limit, {FRAC_W{1'b0}}};
    rnd      = sum + RND;
    plim_ext = {1'b0, cfg_i.power_limit};
    if (sum > pl) begin
      pwr = plim_ext;
    end else if (sum < -pl) begin
      pwr = ~plim_ext + 1'b1;
    end else begin
      pwr = rnd[FRAC_W+PWR_W-1:FRAC_W];
    end
    power_nxt = flags5_r.active ? pwr : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_power    <= power_nxt;
      pivot_drive    <= flags5_r.active & flags5_r.turn;
      clear_encoders <= flags5_r.clear;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pid_drive_controller_core.sv
// pid_drive_controller_core: top level of the pid drive controller.
// Depends on pdc_pkg, pdc_cfg, pdc_meas and pdc_law.
//
// One word on the in_ channel is one control tick: setpoint, three left and
// three right positions, clear and turn flags. Each tick gives exactly one
// word on the out_ channel: saturated drive power, pivot flag, clear echo.
// Both channels are valid/ready; the config port is apb-style with pready
// tied high, registers at byte address 4*i.
// A word passes through the input register, sum, divide, error, integral
// update, gain products and result register in that order. Throughput: one
// word per cycle while the receiver does not stall; the integral and last
// error update, one add and clamp in a single stage, sets that figure.
// When the receiver stalls the whole pipeline holds and in_ready drops, so
// up to seven words sit inside with nothing lost or repeated.
// Reset (synchronous, rst_n low) empties the pipeline, zeroes the integral
// and last error and loads the default gains and limits.
`timescale 1ns / 1ps
`default_nettype none

module pid_drive_controller_core #(
  parameter int unsigned POS_WIDTH       = pdc_pkg::POS_WIDTH_DEF,
  parameter int unsigned MOTORS_PER_SIDE = pdc_pkg::MOTORS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [POS_WIDTH-1:0]         in_setpoint,
  input  wire [POS_WIDTH-1:0]         in_left_pos_a,
  input  wire [POS_WIDTH-1:0]         in_left_pos_b,
  input  wire [POS_WIDTH-1:0]         in_left_pos_c,
  input  wire [POS_WIDTH-1:0]         in_right_pos_a,
  input  wire [POS_WIDTH-1:0]         in_right_pos_b,
  input  wire [POS_WIDTH-1:0]         in_right_pos_c,
  input  wire                         in_clear_request,
  input  wire                         in_turning_mode,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [pdc_pkg::PWR_W-1:0]   out_drive_power,
  output logic                        out_pivot_drive,
  output logic                        out_clear_encoders,
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire [pdc_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire [pdc_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [pdc_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import pdc_pkg::*;

  logic              adv;
  pdc_cfg_t          cfg;
  logic              meas_vld;
  pdc_flags_t        meas_flags;
  logic [ERR_W-1:0]  meas_err;

  // pipeline moves whenever the result register is empty or being taken
  assign adv        = !out_valid || out_ready;
  assign in_ready   = adv;
  assign cfg_pready = 1'b1;

  pdc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg_o   (cfg)
  );

  pdc_meas #(
    .POS_WIDTH       (POS_WIDTH),
    .MOTORS_PER_SIDE (MOTORS_PER_SIDE)
  ) u_meas (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .setpoint      (in_setpoint),
    .left_pos_a    (in_left_pos_a),
    .left_pos_b    (in_left_pos_b),
    .left_pos_c    (in_left_pos_c),
    .right_pos_a   (in_right_pos_a),
    .right_pos_b   (in_right_pos_b),
    .right_pos_c   (in_right_pos_c),
    .clear_request (in_clear_request),
    .turning_mode  (in_turning_mode),
    .vld_o         (meas_vld),
    .flags_o       (meas_flags),
    .err_o         (meas_err)
  );

  pdc_law u_law (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .vld_i          (meas_vld),
    .flags_i        (meas_flags),
    .err_i          (meas_err),
    .cfg_i          (cfg),
    .out_valid      (out_valid),
    .drive_power    (out_drive_power),
    .pivot_drive    (out_pivot_drive),
    .clear_encoders (out_clear_encoders)
  );

endmodule

`default_nettype wire

>>> bench/pid_drive_controller_core_tb.sv
// pid_drive_controller_core_tb: self-checking bench for the pid drive controller core.
// Needs pdc_pkg and the core RTL. It predicts every out_ word from its own model of the
// controller state and checks it, across several gain and limit settings.
`timescale 1ns / 1ps

module pid_drive_controller_core_tb;
  import pdc_pkg::*;

  localparam int unsigned POS_W = POS_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PIPE_DEPTH = 7;
  localparam longint ERR_HI = (longint'(1) <<< (ERR_W - 1)) - 1;
  localparam longint ERR_LO = -(longint'(1) <<< (ERR_W - 1));
  localparam longint TERM_LIM = longint'(1) <<< 60;

  typedef struct packed {
    logic [POS_W-1:0] setpoint;
    logic [POS_W-1:0] left_a;
    logic [POS_W-1:0] left_b;
    logic [POS_W-1:0] left_c;
    logic [POS_W-1:0] right_a;
    logic [POS_W-1:0] right_b;
    logic [POS_W-1:0] right_c;
    logic             clear;
    logic             turn;
  } ctrl_tick_t;

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic             pivot;
    logic             clear_enc;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  ctrl_tick_t drv_tick = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PWR_W-1:0] out_drive_power;
  logic out_pivot_drive;
  logic out_clear_encoders;

  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  ctrl_tick_t tick_q[$];
  drive_word_t drive_q[$];

  pdc_cfg_t drive_cfg = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, ILIM_RST, PLIM_RST};
  longint integ_acc = 0;
  longint last_err = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int word_count = 0;
  int stall_cycles = 0;
  logic [POS_W-1:0] track_sp = '0;

  pid_drive_controller_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_setpoint       (drv_tick.setpoint),
    .in_left_pos_a     (drv_tick.left_a),
    .in_left_pos_b     (drv_tick.left_b),
    .in_left_pos_c     (drv_tick.left_c),
    .in_right_pos_a    (drv_tick.right_a),
    .in_right_pos_b    (drv_tick.right_b),
    .in_right_pos_c    (drv_tick.right_c),
    .in_clear_request  (drv_tick.clear),
    .in_turning_mode   (drv_tick.turn),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_power   (out_drive_power),
    .out_pivot_drive   (out_pivot_drive),
    .out_clear_encoders(out_clear_encoders),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint pos_val(logic [POS_W-1:0] p);
    return longint'($signed(p));
  endfunction

  // advances the integral and last error and returns the word this tick gives
  function automatic drive_word_t predict_drive(ctrl_tick_t t);
    longint sp, lsum, rsum, meas, err, der, lim, tp, ti, td, total, plim_q, pwr;
    drive_word_t w;
    w = '0;
    w.clear_enc = t.clear;
    sp = pos_val(t.setpoint);
    if (t.clear) begin
      integ_acc = 0;
    end
    if (sp != 0) begin
      lsum = pos_val(t.left_a) + pos_val(t.left_b) + pos_val(t.left_c);
      rsum = pos_val(t.right_a) + pos_val(t.right_b) + pos_val(t.right_c);
      // mean truncates toward zero
      meas = t.turn ? rsum / 3 : (lsum + rsum) / 6;
      err = clip(sp - meas, ERR_LO, ERR_HI);
      lim = longint'(drive_cfg.integral_limit);
      integ_acc = clip(integ_acc + err, -lim, lim);
      der = err - last_err;
      last_err = err;
      tp = clip(err * longint'(drive_cfg.gain_p), -TERM_LIM, TERM_LIM);
      ti = clip(integ_acc * longint'(drive_cfg.gain_i), -TERM_LIM, TERM_LIM);
      td = clip(der * longint'(drive_cfg.gain_d), -TERM_LIM, TERM_LIM);
      total = tp + ti + td;
      plim_q = longint'(drive_cfg.power_limit) <<< FRAC_W;
      if (total > plim_q) begin
        pwr = longint'(drive_cfg.power_limit);
      end else if (total < -plim_q) begin
        pwr = -longint'(drive_cfg.power_limit);
      end else begin
        pwr = (total + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      end
      w.power = PWR_W'(pwr);
      w.pivot = t.turn;
    end
    return w;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch word %0d %s: expected %0h got %0h", word_count, what, want, got);
    end
  endtask

  // input side: feed ticks from the pending queue, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drive_q.push_back(predict_drive(drv_tick));
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_tick <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random back-pressure and field-by-field check
  always @(posedge clk) begin
    drive_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          flag_mismatch("unexpected word", '0,
                        {out_drive_power, out_pivot_drive, out_clear_encoders});
        end else begin
          want = drive_q.pop_front();
          if (out_drive_power !== want.power)
            flag_mismatch("drive_power", want.power, out_drive_power);
          if (out_pivot_drive !== want.pivot)
            flag_mismatch("pivot_drive", want.pivot, out_pivot_drive);
          if (out_clear_encoders !== want.clear_enc)
            flag_mismatch("clear_encoders", want.clear_enc, out_clear_encoders);
        end
        word_count++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("pid_drive_controller_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // write one register, then read it back
  task automatic program_reg(reg_idx_t r, logic [APB_DW-1:0] v);
    logic [APB_DW-1:0] readback;
    logic [APB_DW-1:0] stored;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // write lands here; psel stays up as the setup phase of the read
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    case (r)
      REG_GAIN_P:    drive_cfg.gain_p = v;
      REG_GAIN_I:    drive_cfg.gain_i = v;
      REG_GAIN_D:    drive_cfg.gain_d = v;
      REG_INT_LIMIT: drive_cfg.integral_limit = v[ILIM_W-1:0];
      REG_PWR_LIMIT: drive_cfg.power_limit = v[PLIM_W-1:0];
      default: ;
    endcase
    case (r)
      REG_GAIN_P:    stored = drive_cfg.gain_p;
      REG_GAIN_I:    stored = drive_cfg.gain_i;
      REG_GAIN_D:    stored = drive_cfg.gain_d;
      REG_INT_LIMIT: stored = APB_DW'(drive_cfg.integral_limit);
      default:       stored = APB_DW'(drive_cfg.power_limit);
    endcase
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    readback = cfg_prdata;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== stored) flag_mismatch("register readback", stored, readback);
  endtask

  task automatic program_all(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                             logic [31:0] il, logic [31:0] pl);
    program_reg(REG_GAIN_P, gp);
    program_reg(REG_GAIN_I, gi);
    program_reg(REG_GAIN_D, gd);
    program_reg(REG_INT_LIMIT, il);
    program_reg(REG_PWR_LIMIT, pl);
  endtask

  task automatic push_tick(logic [POS_W-1:0] sp, logic [POS_W-1:0] la, logic [POS_W-1:0] lb,
                           logic [POS_W-1:0] lc, logic [POS_W-1:0] ra, logic [POS_W-1:0] rb,
                           logic [POS_W-1:0] rc, logic clr, logic turn);
    tick_q.push_back('{sp, la, lb, lc, ra, rb, rc, clr, turn});
  endtask

  // mostly tracking runs around a held setpoint, with zero setpoints and raw noise mixed in
  task automatic queue_random_ticks(int count);
    ctrl_tick_t t;
    int kind;
    int spread;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if ($urandom_range(9) == 0) track_sp = POS_W'($urandom());
      spread = 1 << $urandom_range(12);
      t.setpoint = track_sp;
      t.left_a = track_sp + POS_W'($urandom_range(2 * spread) - spread);
      t.left_b = track_sp + POS_W'($urandom_range(2 * spread) - spread);
      t.left_c = track_sp + POS_W'($urandom_range(2 * spread) - spread);
      t.right_a = track_sp + POS_W'($urandom_range(2 * spread) - spread);
      t.right_b = track_sp + POS_W'($urandom_range(2 * spread) - spread);
      t.right_c = track_sp + POS_W'($urandom_range(2 * spread) - spread);
      if (kind >= 70) begin
        t.setpoint = POS_W'($urandom());
        t.left_a = POS_W'($urandom());
        t.left_b = POS_W'($urandom());
        t.left_c = POS_W'($urandom());
        t.right_a = POS_W'($urandom());
        t.right_b = POS_W'($urandom());
        t.right_c = POS_W'($urandom());
      end
      if (kind < 10) t.setpoint = '0;
      t.clear = ($urandom_range(19) == 0);
      t.turn = ($urandom_range(2) == 0);
      tick_q.push_back(t);
    end
  endtask

  // sender holds off until every expected word is back
  task automatic wait_drained;
    do @(negedge clk); while (tick_q.size() != 0 || in_valid || drive_q.size() != 0);
    repeat (2 * PIPE_DEPTH) @(negedge clk);
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (!rst_n);

    // zero setpoint: no power, no pivot, state untouched
    push_tick(0, 100, 200, 300, 400, 500, 600, 1'b0, 1'b0);
    push_tick(0, -5, 7, 9, 11, -13, 15, 1'b0, 1'b1);
    push_tick(0, 1, 2, 3, 4, 5, 6, 1'b1, 1'b0);
    push_tick(160, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    push_tick(160, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    // turning uses the right side only
    push_tick(160, 24'h7fffff, 24'h800000, 24'h123456, 10, 11, 12, 1'b0, 1'b1);
    // negative means truncate toward zero
    push_tick(1, 0, 0, 0, -1, -1, 0, 1'b0, 1'b1);
    push_tick(1, -1, -1, -1, -1, -1, 0, 1'b0, 1'b0);
    push_tick(160, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
    // full-scale errors drive the integral clamp and power saturation
    push_tick(24'h7fffff, 24'h800000, 24'h800000, 24'h800000,
              24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    push_tick(24'h7fffff, 24'h800000, 24'h800000, 24'h800000,
              24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b1);
    push_tick(24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0, 1'b0);
    push_tick(24'h800000, 24'hffffff, 24'hffffff, 24'hffffff,
              24'hffffff, 24'hffffff, 24'hffffff, 1'b0, 1'b1);
    push_tick(-160, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    push_tick(160, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    push_tick(1, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
    push_tick(-1, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    push_tick(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0, 1'b0);
    push_tick(5, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    push_tick(24'h800000, 0, 0, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0, 1'b1);
    push_tick(0, 24'h800000, 0, 0, 0, 0, 24'h7fffff, 1'b1, 1'b1);
    push_tick(16, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
    wait_drained();

    set_idle(0, 0);
    queue_random_ticks(200);
    wait_drained();

    // every register at its top value
    program_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'd2047);
    set_idle(84, 0);
    queue_random_ticks(200);
    wait_drained();

    program_all('0, '0, '0, '0, '0);
    set_idle(0, 84);
    queue_random_ticks(100);
    wait_drained();

    program_all($urandom_range(1 << 22), $urandom_range(1 << 14), $urandom_range(1 << 20),
                $urandom_range(200000), $urandom_range(2047));
    set_idle(34, 34);
    queue_random_ticks(250);
    wait_drained();

    program_all($urandom(), $urandom(), $urandom(), $urandom() & 32'h7fffffff,
                $urandom() & 32'h7ff);
    set_idle(0, 0);
    queue_random_ticks(200);
    wait_drained();

    program_all($urandom_range(1 << 22), $urandom_range(1 << 14), $urandom_range(1 << 20),
                $urandom_range(200000), $urandom_range(2047));
    set_idle(0, 84);
    queue_random_ticks(150);
    wait_drained();

    program_all(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, 32'(ILIM_RST), 32'(PLIM_RST));
    set_idle(34, 34);
    queue_random_ticks(100);
    wait_drained();
    repeat (4 * PIPE_DEPTH) @(negedge clk);

    if (mismatches == 0) begin
      $display("pid_drive_controller_core regression: pass");
    end else begin
      $display("pid_drive_controller_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_cfg.sv
hw/rtl/pdc_meas.sv
hw/rtl/pdc_law.sv
hw/rtl/pid_drive_controller_core.sv
bench/pid_drive_controller_core_tb.sv
